FILE: src/bounded_double_ended_list_unit_macros.svh
// Assertion macros for the bounded double-ended list unit.
// Used inside modules that have clk and rst_n in scope.
`ifndef BOUNDED_DOUBLE_ENDED_LIST_UNIT_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_LIST_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BDEL_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BDEL_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error(msg);

`endif

FILE: src/bdel_pkg.sv
// Shared types and constants of the bounded double-ended list unit.
// No dependencies.
`timescale 1ns / 1ps

package bdel_pkg;

  localparam int FUNC_W  = 3;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 9;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_HEAD  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_TAIL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd4;

  // broadcast to every cell of the row
  typedef struct packed {
    logic push_front;  // shift row toward the tail, cell 0 takes the new word
    logic pop_front;   // shift row toward the head
    logic push_back;   // cell at index == count takes the new word
    logic snap;        // copy stored words into the read-out chain
    logic scan;        // shift read-out chain one cell toward the head
  } cell_ctrl_t;

endpackage

FILE: src/bdel_ifs.sv
// Valid/ready channel interfaces of the bounded double-ended list unit.
// Depends on bdel_pkg.
`timescale 1ns / 1ps

interface bdel_in_if;
  logic                             valid;
  logic                             ready;
  logic [bdel_pkg::FUNC_W-1:0]      func;
  logic [bdel_pkg::DATA_W-1:0]      elem_value;
  logic [bdel_pkg::POS_W-1:0]       position;

  modport source (output valid, output func, output elem_value, output position,
                  input ready);
  modport sink   (input valid, input func, input elem_value, input position,
                  output ready);
endinterface

interface bdel_out_if;
  logic                             valid;
  logic                             ready;
  logic [bdel_pkg::DATA_W-1:0]      read_value;
  logic                             accepted;
  logic [bdel_pkg::COUNT_W-1:0]     count;

  modport source (output valid, output read_value, output accepted, output count,
                  input ready);
  modport sink   (input valid, input read_value, input accepted, input count,
                  output ready);
endinterface

FILE: src/bounded_double_ended_list_unit.sv
// Bounded double-ended list: CAPACITY words held in a row of cells, cell k
// holding the word at position k from the head. Each accepted word gives one
// result. Inserts, removals and out-of-range reads finish in the accept cycle
// and their result is shown on the next cycle; a read at a valid position p
// snaps the row into the read-out chain, which shifts it toward cell 0 one cell
// per cycle until word p reaches cell 0. A new word is taken once the previous
// result has been taken or is being taken and no read-out is in flight.
// No clearing pass after reset; cells beyond the count are never read.
`timescale 1ns / 1ps
`include "bounded_double_ended_list_unit_macros.svh"

module bounded_double_ended_list_unit #(
  parameter int CAPACITY   = 256,
  parameter int ELEM_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  bdel_in_if.sink    in_if,
  bdel_out_if.source out_if
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = bdel_pkg::POS_W;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                          state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [POS_W-1:0]              remain_r, remain_nxt;
  logic                          out_valid_r;
  logic [bdel_pkg::DATA_W-1:0]   read_value_r;
  logic                          accepted_r;
  logic [bdel_pkg::COUNT_W-1:0]  count_out_r;

  logic                 accept, full, empty, pos_ok, ok, rd_start, scan_done;
  logic                 scan_st, ins_ok;
  bdel_pkg::cell_ctrl_t ctrl;
  logic [ELEM_WIDTH-1:0] in_elem;

  logic [ELEM_WIDTH-1:0] val_w   [CAPACITY];
  logic [ELEM_WIDTH-1:0] bus_w   [CAPACITY];
  logic [ELEM_WIDTH-1:0] left_w  [CAPACITY];
  logic [ELEM_WIDTH-1:0] right_w [CAPACITY];
  logic [ELEM_WIDTH-1:0] rbus_w  [CAPACITY];

  assign in_if.ready = rst_n && (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;
  assign full        = (count_r == CAP_C);
  assign empty       = (count_r == '0);
  assign pos_ok      = CMP_W'(in_if.position) < CMP_W'(count_r);
  assign in_elem     = ELEM_WIDTH'(in_if.elem_value);
  assign scan_done   = (state_r == ST_SCAN) && (remain_r == '0);
  assign scan_st     = (state_r == ST_SCAN);
  assign ins_ok      = ctrl.push_front || ctrl.push_back;

  always_comb begin
    ctrl       = '0;
    ok         = 1'b0;
    rd_start   = 1'b0;
    count_nxt  = count_r;
    state_nxt  = state_r;
    remain_nxt = remain_r;
    if (accept) begin
      case (in_if.func)
        bdel_pkg::FUNC_PUSH_HEAD: begin
          if (!full) begin
            ctrl.push_front = 1'b1;
            ok              = 1'b1;
            count_nxt       = count_r + 1'b1;
          end
        end
        bdel_pkg::FUNC_PUSH_TAIL: begin
          if (!full) begin
            ctrl.push_back = 1'b1;
            ok             = 1'b1;
            count_nxt      = count_r + 1'b1;
          end
        end
        bdel_pkg::FUNC_POP_HEAD: begin
          if (!empty) begin
            ctrl.pop_front = 1'b1;
            ok             = 1'b1;
            count_nxt      = count_r - 1'b1;
          end
        end
        bdel_pkg::FUNC_POP_TAIL: begin
          if (!empty) begin
            ok        = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        bdel_pkg::FUNC_READ: begin
          if (pos_ok) begin
            ctrl.snap  = 1'b1;
            rd_start   = 1'b1;
            state_nxt  = ST_SCAN;
            remain_nxt = in_if.position;
          end
        end
        default: begin
        end
      endcase
    end
    if (state_r == ST_SCAN) begin
      if (remain_r == '0) begin
        state_nxt = ST_IDLE;
      end else begin
        ctrl.scan  = 1'b1;
        remain_nxt = remain_r - 1'b1;
      end
    end
  end

  // neighbor wiring of the row; ends see the new word, themselves, or zero
  for (genvar k = 0; k < CAPACITY; k++) begin : g_row
    if (k == 0) begin : g_first
      assign left_w[k] = in_elem;
    end else begin : g_mid_l
      assign left_w[k] = val_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w[k] = val_w[k];
      assign rbus_w[k]  = '0;
    end else begin : g_mid_r
      assign right_w[k] = val_w[k+1];
      assign rbus_w[k]  = bus_w[k+1];
    end

    bdel_cell #(
      .ELEM_W (ELEM_WIDTH),
      .CNT_W  (CNT_W),
      .IDX    (k)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .new_value   (in_elem),
      .left_value  (left_w[k]),
      .right_value (right_w[k]),
      .right_bus   (rbus_w[k]),
      .value       (val_w[k]),
      .bus         (bus_w[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      if ((accept && !rd_start) || scan_done) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      read_value_r <= bdel_pkg::DATA_W'(bus_w[0]);
      accepted_r   <= 1'b1;
      count_out_r  <= bdel_pkg::COUNT_W'(count_r);
    end else if (accept && !rd_start) begin
      read_value_r <= '0;
      accepted_r   <= ok;
      count_out_r  <= bdel_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.read_value = read_value_r;
  assign out_if.accepted   = accepted_r;
  assign out_if.count      = count_out_r;

  `BDEL_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CAP_C, "count above capacity")
  `BDEL_ASSERT_IMP(a_scan_slot_free, scan_st, !out_valid_r, "result slot busy in read-out")
  `BDEL_ASSERT_NXT(a_push_grows, ins_ok, count_r == $past(count_r) + 1'b1, "count not grown")
  `BDEL_ASSERT_NXT(a_read_starts, rd_start, scan_st && remain_r == $past(remain_nxt), "no read-out")

endmodule

FILE: src/bdel_cell.sv
// One storage cell of the list row: holds the word at a fixed position
// plus one stage of the read-out chain. Depends on bdel_pkg.
`timescale 1ns / 1ps

module bdel_cell #(
  parameter int ELEM_W = 32,
  parameter int CNT_W  = 9,
  parameter int IDX    = 0
) (
  input  logic                 clk,
  input  bdel_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]     count,
  input  logic [ELEM_W-1:0]    new_value,
  input  logic [ELEM_W-1:0]    left_value,
  input  logic [ELEM_W-1:0]    right_value,
  input  logic [ELEM_W-1:0]    right_bus,
  output logic [ELEM_W-1:0]    value,
  output logic [ELEM_W-1:0]    bus
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [ELEM_W-1:0] value_r, value_nxt;
  logic [ELEM_W-1:0] bus_r, bus_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.push_front) begin
      value_nxt = left_value;
    end else if (ctrl.pop_front) begin
      value_nxt = right_value;
    end else if (ctrl.push_back && (count == IDX_C)) begin
      value_nxt = new_value;
    end
  end

  always_comb begin
    bus_nxt = bus_r;
    if (ctrl.snap) begin
      bus_nxt = value_r;
    end else if (ctrl.scan) begin
      bus_nxt = right_bus;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    bus_r   <= bus_nxt;
  end

  assign value = value_r;
  assign bus   = bus_r;

endmodule
